@@ src/strip_charge_digitizer_macros.svh @@
// Assertion macros shared by the strip charge digitizer checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef STRIP_CHARGE_DIGITIZER_MACROS_SVH
`define STRIP_CHARGE_DIGITIZER_MACROS_SVH

// Same-cycle implication.
`define SCD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scd check failed: same-cycle implication");

// Next-cycle implication.
`define SCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scd check failed: next-cycle implication");

// Invariant.
`define SCD_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("scd check failed: invariant");

`endif

@@ src/scd_pkg.sv @@
// Shared types, codes and constants for the strip charge digitizer.
// No dependencies.
`timescale 1ns / 1ps

package scd_pkg;

	localparam int OPCODE_W   = 2;
	localparam int SLOT_W     = 5;
	localparam int STRIP_W    = 10;
	localparam int ENERGY_W   = 16;
	localparam int CODE_W     = 3;
	localparam int GAIN_W     = 16;
	localparam int SCOUNT_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = 32;

	localparam logic [OPCODE_W-1:0] OP_HIT  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_MARK = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_COUNT = 2'd1;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd205;
	localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 11'd639;

	localparam int THRESH_N = 8;
	localparam logic [7:0] THRESH [THRESH_N] = '{8'd41, 8'd58, 8'd73, 8'd88,
		8'd103, 8'd118, 8'd133, 8'd140};

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [SLOT_W-1:0]   sensor_slot;
		logic [STRIP_W-1:0]  strip;
		logic [ENERGY_W-1:0] energy_kev;
		logic                dead_flag;
	} scd_in_t;

	typedef struct packed {
		logic [STRIP_W-1:0] strip_index;
		logic [CODE_W-1:0]  adc_code;
	} scd_out_t;

	// Number of thresholds reached, minus one.
	function automatic logic [CODE_W-1:0] code_of(input logic [31:0] sum);
		logic [CODE_W:0] n;
		n = '0;
		for (int i = 0; i < THRESH_N; i++) begin
			if (sum >= 32'(THRESH[i])) begin
				n = n + 1'b1;
			end
		end
		return CODE_W'(n - 1'b1);
	endfunction

endpackage

@@ src/strip_charge_digitizer.sv @@
// Strip charge digitizer: per-strip charge sums, dead masks and threshold readout.
// Accepted items pass the stage 1 registers into the result register; one item is
// accepted per cycle outside stalls, set by the single read-modify-write pass over
// the strip memories (last write forwarded). A readout with a result that finds the
// result register held stalls input until it drains. Reset is asynchronous; then a
// clearing pass zeroes both memories with in_ready low (cfg writes taken throughout).
`timescale 1ns / 1ps

module strip_charge_digitizer #(
	parameter int STRIPS       = 1024,
	parameter int SENSOR_SLOTS = 32,
	parameter int SUM_WIDTH    = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  scd_pkg::scd_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output scd_pkg::scd_out_t                    out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import scd_pkg::*;

	localparam int AW = $clog2(STRIPS);
	localparam int GP_W = PROD_W - 8;
	localparam int ADD_W = ((SUM_WIDTH > GP_W) ? SUM_WIDTH : GP_W) + 1;
	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

	// Storage
	logic [SUM_WIDTH-1:0]    sum_mem  [STRIPS];
	logic [SENSOR_SLOTS-1:0] dead_mem [STRIPS];

	// Config
	logic [GAIN_W-1:0]   gain_q;
	logic [SCOUNT_W-1:0] strip_count_q;

	// Clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Stage 1
	logic                    valid_s1;
	logic                    hit_s1, mark_s1, read_s1;
	logic [AW-1:0]           addr_s1;
	logic [STRIP_W-1:0]      strip_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic                    flag_s1;
	logic [PROD_W-1:0]       prod_s1;
	logic [SUM_WIDTH-1:0]    sum_rd_s1;
	logic [SENSOR_SLOTS-1:0] row_rd_s1;

	// Last write, forwarded to the next read
	logic                    fwd_valid_q;
	logic [AW-1:0]           fwd_addr_q;
	logic [SUM_WIDTH-1:0]    fwd_sum_q;
	logic [SENSOR_SLOTS-1:0] fwd_row_q;

	// Result register
	logic     out_valid_q;
	scd_out_t out_q;

	logic                    in_acc;
	logic                    strip_in;
	logic                    hit_ok;
	logic [AW-1:0]           in_addr;
	logic                    fwd_hit;
	logic [SUM_WIDTH-1:0]    sum_cur;
	logic [SENSOR_SLOTS-1:0] row_cur;
	logic [SENSOR_SLOTS-1:0] slot_mask;
	logic                    is_dead;
	logic                    hit_live;
	logic [ADD_W-1:0]        sum_add;
	logic [SUM_WIDTH-1:0]    sum_sat;
	logic [SUM_WIDTH-1:0]    new_sum;
	logic [SENSOR_SLOTS-1:0] new_row;
	logic                    s1_res;
	logic                    s1_adv;
	logic                    wr_en;

	// Stage 0 decode
	assign in_addr  = AW'(in_data.strip);
	assign strip_in = 32'(in_data.strip) < 32'(STRIPS);
	assign hit_ok   = (in_data.opcode == OP_HIT) && strip_in &&
		({1'b0, in_data.strip} < strip_count_q);

	// Stage 1 read-modify-write
	assign fwd_hit   = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign sum_cur   = fwd_hit ? fwd_sum_q : sum_rd_s1;
	assign row_cur   = fwd_hit ? fwd_row_q : row_rd_s1;
	// Slots past the mask width shift out to an empty mask
	assign slot_mask = SENSOR_SLOTS'(1) << slot_s1;
	assign is_dead   = |(row_cur & slot_mask);
	assign hit_live  = hit_s1 && !is_dead;
	assign sum_add   = ADD_W'(sum_cur) + ADD_W'(prod_s1[PROD_W-1:8]);
	assign sum_sat   = (sum_add > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_WIDTH-1:0];

	always_comb begin
		new_sum = sum_cur;
		if (hit_live) begin
			new_sum = sum_sat;
		end else if (read_s1) begin
			new_sum = '0;
		end
		new_row = row_cur;
		if (mark_s1) begin
			new_row = flag_s1 ? (row_cur | slot_mask) : (row_cur & ~slot_mask);
		end
	end

	assign s1_res   = valid_s1 && read_s1 && (32'(sum_cur) >= 32'(THRESH[0]));
	assign s1_adv   = !s1_res || !out_valid_q || out_ready;
	assign wr_en    = valid_s1 && s1_adv && (hit_live || mark_s1 || read_s1);
	assign in_ready = !clr_busy_q && (!valid_s1 || s1_adv);
	assign in_acc   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RESET;
			strip_count_q <= SCOUNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN:        gain_q        <= cfg_data;
				REG_STRIP_COUNT: strip_count_q <= cfg_data[SCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(STRIPS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Memories: clear sweep or stage 1 write back, read on accept
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			sum_mem[clr_addr_q]  <= '0;
			dead_mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			sum_mem[addr_s1]  <= new_sum;
			dead_mem[addr_s1] <= new_row;
		end
		if (in_acc) begin
			sum_rd_s1 <= sum_mem[in_addr];
			row_rd_s1 <= dead_mem[in_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hit_s1   <= hit_ok;
			mark_s1  <= (in_data.opcode == OP_MARK) && strip_in;
			read_s1  <= (in_data.opcode == OP_READ) && strip_in;
			addr_s1  <= in_addr;
			strip_s1 <= in_data.strip;
			slot_s1  <= in_data.sensor_slot;
			flag_s1  <= in_data.dead_flag;
			prod_s1  <= PROD_W'(in_data.energy_kev) * PROD_W'(gain_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_sum_q  <= new_sum;
			fwd_row_q  <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_res && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the beat until taken
	always_ff @(posedge clk) begin
		if (s1_res && s1_adv) begin
			out_q.strip_index <= strip_s1;
			out_q.adc_code    <= code_of(32'(sum_cur));
		end
	end

endmodule

@@ src/scd_checker.sv @@
// Port-level checks for strip_charge_digitizer, bound to the top level.
// Depends on scd_pkg and strip_charge_digitizer_macros.svh.
`timescale 1ns / 1ps
`include "strip_charge_digitizer_macros.svh"

module scd_checker #(
	parameter int STRIPS = 1024
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input scd_pkg::scd_out_t out_data,
	input logic              cfg_ready
);

	// A result beat holds until taken
	`SCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// Results only name strips that exist
	`SCD_ASSERT_IMPLY(a_out_strip, out_valid, 32'(out_data.strip_index) < 32'(STRIPS))

	// Input stalls only behind a held result once the clear is done
	`SCD_ASSERT_IMPLY(a_stall_cause, $fell(in_ready), out_valid && !out_ready)

	// Register writes are never back-pressured
	`SCD_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)

endmodule

bind strip_charge_digitizer scd_checker #(.STRIPS(STRIPS)) u_scd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);

@@ tb/sv/strip_charge_digitizer_tb.sv @@
// Self-checking bench for strip_charge_digitizer: queued hit, mark and readout beats
// are predicted against a local copy of the strip sums and dead masks.
// Depends on scd_pkg and the strip_charge_digitizer RTL.
`timescale 1ns / 1ps

module strip_charge_digitizer_tb;
	import scd_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int STRIP_TOTAL = 1024;
	localparam int SLOT_TOTAL = 32;
	localparam logic [14:0] SUM_CAP = 15'h7fff;
	localparam logic [STRIP_W-1:0] STRIP_POOL [8] = '{10'd0, 10'd1, 10'd2, 10'd3,
		10'd638, 10'd639, 10'd640, 10'd1023};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	scd_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	scd_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Local copy of the block state and registers.
	logic [14:0] charge_sum [STRIP_TOTAL];
	bit dead_bits [SLOT_TOTAL][STRIP_TOTAL];
	logic [GAIN_W-1:0] gain_reg = GAIN_RESET;
	logic [SCOUNT_W-1:0] strip_limit = SCOUNT_RESET;

	scd_in_t digitizer_items [$];
	scd_out_t pending_codes [$];
	int items_queued = 0;
	int items_taken = 0;
	int codes_predicted = 0;
	int codes_seen = 0;
	int mismatches = 0;
	bit steady = 1'b0;

	strip_charge_digitizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		foreach (charge_sum[i]) charge_sum[i] = '0;
	end

	task automatic digitize_item(input scd_in_t it, output bit fires, output scd_out_t res);
		logic [32:0] total;
		logic [14:0] level;
		int reached;
		fires = 1'b0;
		res = '0;
		case (it.opcode)
			OP_HIT: begin
				// A strip count above the strip total admits every strip anyway.
				if (11'(it.strip) < strip_limit && !dead_bits[it.sensor_slot][it.strip]) begin
					total = 33'(charge_sum[it.strip])
						+ 33'((32'(it.energy_kev) * 32'(gain_reg)) >> 8);
					charge_sum[it.strip] = (total > 33'(SUM_CAP)) ? SUM_CAP : total[14:0];
				end
			end
			OP_MARK: begin
				dead_bits[it.sensor_slot][it.strip] = it.dead_flag;
			end
			OP_READ: begin
				level = charge_sum[it.strip];
				charge_sum[it.strip] = '0;
				reached = 0;
				for (int i = 0; i < THRESH_N; i++) begin
					if (level >= 15'(THRESH[i])) begin
						reached++;
					end
				end
				if (reached > 0) begin
					fires = 1'b1;
					res.strip_index = it.strip;
					res.adc_code = CODE_W'(reached - 1);
				end
			end
			default: ;
		endcase
	endtask

	// Input side: predict on every accepted beat, then load the next pending item.
	always @(posedge clk) begin : item_driver
		scd_out_t res;
		bit fires;
		if (in_valid && in_ready) begin
			digitize_item(in_data, fires, res);
			if (fires) begin
				pending_codes = {pending_codes, res};
				codes_predicted <= codes_predicted + 1;
			end
			items_taken <= items_taken + 1;
		end
		if (!in_valid || in_ready) begin
			if (arst_n && digitizer_items.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
				in_data <= digitizer_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side: compare each result beat with the oldest prediction.
	always @(posedge clk) begin : result_check
		scd_out_t want;
		if (out_valid && out_ready) begin
			codes_seen <= codes_seen + 1;
			if (pending_codes.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected beat: strip %0d code %0d",
						out_data.strip_index, out_data.adc_code);
				end
				mismatches++;
			end else begin
				want = pending_codes.pop_front();
				if (out_data.strip_index !== want.strip_index
						|| out_data.adc_code !== want.adc_code) begin
					if (mismatches < 10) begin
						$display("got strip %0d code %0d, expected strip %0d code %0d",
							out_data.strip_index, out_data.adc_code,
							want.strip_index, want.adc_code);
					end
					mismatches++;
				end
			end
		end
		out_ready <= steady || ($urandom_range(99) >= 8);
	end

	task automatic enqueue(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
			input logic [STRIP_W-1:0] strip, input logic [ENERGY_W-1:0] energy,
			input logic flag);
		scd_in_t it;
		it.opcode = op;
		it.sensor_slot = slot;
		it.strip = strip;
		it.energy_kev = energy;
		it.dead_flag = flag;
		digitizer_items = {digitizer_items, it};
		items_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_GAIN) begin
			gain_reg = value;
		end else if (idx == REG_STRIP_COUNT) begin
			strip_limit = value[SCOUNT_W-1:0];
		end
	endtask

	// Hold until every queued item is taken and every predicted code has come back,
	// then give the pipeline time to finish readouts that produce nothing.
	task automatic settle();
		do @(posedge clk);
		while (items_taken != items_queued || codes_seen != codes_predicted);
		repeat (6) @(posedge clk);
	endtask

	// Mostly hit bursts closed by a readout on one strip, with random noise beats mixed in.
	task automatic queue_random(input int quota);
		int made;
		int hits;
		logic [STRIP_W-1:0] s;
		logic [SLOT_W-1:0] slot;
		made = 0;
		while (made < quota) begin
			if ($urandom_range(99) < 20) begin
				enqueue(OPCODE_W'($urandom_range(3)), SLOT_W'($urandom_range(31)),
					STRIP_W'($urandom_range(1023)), ENERGY_W'($urandom_range(65535)),
					1'($urandom_range(1)));
				made++;
			end else begin
				s = ($urandom_range(3) != 0) ? STRIP_POOL[$urandom_range(7)]
					: STRIP_W'($urandom_range(1023));
				slot = ($urandom_range(9) < 7) ? SLOT_W'($urandom_range(1))
					: SLOT_W'($urandom_range(31));
				hits = $urandom_range(4, 1);
				repeat (hits) begin
					enqueue(OP_HIT, slot, s, ($urandom_range(9) == 0)
						? ENERGY_W'($urandom_range(65535)) : ENERGY_W'($urandom_range(80)),
						1'b0);
				end
				if ($urandom_range(99) < 15) begin
					enqueue(OP_MARK, slot, s, ENERGY_W'($urandom_range(65535)),
						1'($urandom_range(1)));
				end
				enqueue(OP_READ, slot, s, '0, 1'b0);
				made += hits + 1;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset gain of 205/256.
		enqueue(OP_HIT, 5'd0, 10'd5, 16'd60, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd5, 16'd0, 1'b0);
		enqueue(OP_HIT, 5'd0, 10'd5, 16'hffff, 1'b0);
		enqueue(OP_HIT, 5'd0, 10'd5, 16'hffff, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd5, 16'd0, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd5, 16'd0, 1'b0);
		enqueue(OP_HIT, 5'd0, 10'd6, 16'd45, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd6, 16'd0, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd6, 16'd0, 1'b0);
		enqueue(OP_HIT, 5'd3, 10'd9, 16'd52, 1'b0);
		enqueue(OP_READ, 5'd3, 10'd9, 16'd0, 1'b0);
		enqueue(OP_HIT, 5'd3, 10'd9, 16'd51, 1'b0);
		enqueue(OP_READ, 5'd3, 10'd9, 16'd0, 1'b0);
		// Dead strip on one slot only.
		enqueue(OP_MARK, 5'd31, 10'd7, 16'd0, 1'b1);
		enqueue(OP_HIT, 5'd31, 10'd7, 16'd1000, 1'b0);
		enqueue(OP_HIT, 5'd0, 10'd7, 16'd100, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd7, 16'd0, 1'b0);
		enqueue(OP_MARK, 5'd31, 10'd7, 16'd0, 1'b0);
		enqueue(OP_HIT, 5'd31, 10'd7, 16'd200, 1'b0);
		enqueue(OP_READ, 5'd31, 10'd7, 16'd0, 1'b0);
		// Edge of the strip count.
		enqueue(OP_HIT, 5'd0, 10'd638, 16'd100, 1'b0);
		enqueue(OP_HIT, 5'd0, 10'd639, 16'd100, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd638, 16'd0, 1'b0);
		enqueue(OP_READ, 5'd0, 10'd639, 16'd0, 1'b0);
		enqueue(OP_HIT, 5'd0, 10'd1023, 16'd100, 1'b0);
		enqueue(OP_UNUSED, 5'd31, 10'd1023, 16'hffff, 1'b1);
		enqueue(OP_READ, 5'd0, 10'd1023, 16'd0, 1'b0);
		settle();

		write_reg(REG_GAIN, 16'd256);
		write_reg(REG_STRIP_COUNT, 16'd1024);
		queue_random(300);
		settle();

		write_reg(REG_GAIN, 16'd0);
		write_reg(REG_STRIP_COUNT, 16'd0);
		queue_random(100);
		settle();

		write_reg(REG_GAIN, 16'hffff);
		write_reg(REG_STRIP_COUNT, 16'd1);
		queue_random(150);
		settle();

		steady = 1'b1;
		write_reg(REG_GAIN, 16'($urandom_range(1023, 1)));
		write_reg(REG_STRIP_COUNT, 16'd2047);
		queue_random(300);
		settle();
		steady = 1'b0;

		write_reg(REG_GAIN, 16'd384);
		write_reg(REG_STRIP_COUNT, 16'd700);
		queue_random(400);
		settle();

		mismatches += pending_codes.size();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/scd_pkg.sv
src/strip_charge_digitizer.sv
src/scd_checker.sv
tb/sv/strip_charge_digitizer_tb.sv
